FILE: design/u128dr_pkg.sv
package u128dr_pkg;

  localparam int DEFAULT_WORD_BITS = 128;
  localparam int FIELD_BITS        = 64;
  localparam int FULL_BITS         = 2 * FIELD_BITS;
  localparam int SCALE_BITS        = 7;
  localparam int STATUS_BITS       = 2;
  // Dividend bits consumed per cycle by the divide-by-ten step.
  localparam int DIG_BITS          = 8;
  localparam int REM10_BITS        = 4;
  localparam logic [REM10_BITS:0] TEN = 5'd10;

  localparam logic [STATUS_BITS-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_OVF  = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_DIVZ = 2'd2;

  localparam logic CMD_RESCALE = 1'b0;
  localparam logic CMD_DIVIDE  = 1'b1;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_MUL10,
    OP_DIV10,
    OP_DIV
  } op_e;

  // Sequencer to datapath.
  typedef struct packed {
    op_e  op;
    logic first;  // first byte of a divide-by-ten pass
    logic err;    // force the answer to zero
  } ctl_t;

  // Datapath to sequencer.
  typedef struct packed {
    logic ovf;       // the next multiply by ten would leave the word
    logic val_zero;
    logic div_zero;
  } stat_t;

endpackage

FILE: design/u128_decimal_rescale_divide_unit.sv
// Channel   Direction  Handshake          Beat contents
// command   in         start_i, busy_o    cmd, value, divisor, decimal_scale
// result    out        done_o             answer_low, answer_high, status
//
// A command beat is taken when start_i is high and busy_o is low. Every
// command gives one result beat, shown for the single cycle in which done_o
// is high; the receiver cannot stall it, and a new command may be taken in
// that same cycle. A rescale by +k multiplies by ten k times, stopping early on
// overflow; a rescale by -k divides by ten a byte per step until k digits are gone
// or the value is zero; a divide with scale k >= 0 multiplies likewise, then takes
// WORD_BITS quotient bits, a divide with a negative scale only divides, and a zero
// divisor skips both; the shared shift-add and shift-subtract datapath does it.
// Reset is asynchronous and active low and returns the sequencer to idle.
module u128_decimal_rescale_divide_unit #(
  parameter int WORD_BITS = u128dr_pkg::DEFAULT_WORD_BITS
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start_i,
  output logic                                     busy_o,
  input  logic                                     cmd_i,
  input  logic [u128dr_pkg::FIELD_BITS-1:0]        value_low_i,
  input  logic [u128dr_pkg::FIELD_BITS-1:0]        value_high_i,
  input  logic [u128dr_pkg::FIELD_BITS-1:0]        divisor_low_i,
  input  logic [u128dr_pkg::FIELD_BITS-1:0]        divisor_high_i,
  input  logic signed [u128dr_pkg::SCALE_BITS-1:0] decimal_scale_i,
  output logic                                     done_o,
  output logic [u128dr_pkg::FIELD_BITS-1:0]        answer_low_o,
  output logic [u128dr_pkg::FIELD_BITS-1:0]        answer_high_o,
  output logic [u128dr_pkg::STATUS_BITS-1:0]       status_o
);
  import u128dr_pkg::*;

  ctl_t                 ctl;
  stat_t                stat;
  logic [FULL_BITS-1:0] answer;

  u128dr_ctrl #(
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .cmd_i    (cmd_i),
    .scale_i  (decimal_scale_i),
    .stat_i   (stat),
    .ctl_o    (ctl),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .status_o (status_o)
  );

  u128dr_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .value_i   ({value_high_i, value_low_i}),
    .divisor_i ({divisor_high_i, divisor_low_i}),
    .stat_o    (stat),
    .answer_o  (answer)
  );

  assign answer_low_o  = answer[FIELD_BITS-1:0];
  assign answer_high_o = answer[FULL_BITS-1:FIELD_BITS];

endmodule

FILE: design/u128dr_datapath.sv
module u128dr_datapath #(
  parameter int WORD_BITS = u128dr_pkg::DEFAULT_WORD_BITS
) (
  input  logic                              clk_i,
  input  u128dr_pkg::ctl_t                  ctl_i,
  input  logic [u128dr_pkg::FULL_BITS-1:0]  value_i,
  input  logic [u128dr_pkg::FULL_BITS-1:0]  divisor_i,
  output u128dr_pkg::stat_t                 stat_o,
  output logic [u128dr_pkg::FULL_BITS-1:0]  answer_o
);
  import u128dr_pkg::*;

  localparam int NCHUNK = (WORD_BITS + DIG_BITS - 1) / DIG_BITS;
  localparam int PAD    = NCHUNK * DIG_BITS;

  // The value register is padded to whole bytes for the divide-by-ten pass;
  // the bits above WORD_BITS stay zero outside that pass.
  logic [PAD-1:0]        val_q, val_d;
  logic [WORD_BITS-1:0]  div_q, div_d;
  logic [WORD_BITS-1:0]  rem_q, rem_d;
  logic [REM10_BITS-1:0] rem10_q, rem10_d;

  logic [WORD_BITS+3:0]  prod;
  logic [WORD_BITS:0]    trial;
  logic [WORD_BITS+1:0]  diff;
  logic                  ge;
  logic [PAD-1:0]        load_val;
  logic [PAD-1:0]        mul_val;
  logic [PAD-1:0]        div_val;
  logic [PAD-1:0]        d10_val;
  logic [REM10_BITS-1:0] d10_rem;

  // Multiply by ten as 8x + 2x, four guard bits catch any wrap.
  assign prod = ({4'b0, val_q[WORD_BITS-1:0]} << 3) + ({4'b0, val_q[WORD_BITS-1:0]} << 1);

  // One restoring shift-subtract step of the general divide.
  assign trial = {rem_q, val_q[WORD_BITS-1]};
  assign diff  = {1'b0, trial} - {2'b0, div_q};
  assign ge    = ~diff[WORD_BITS+1];

  always_comb begin
    load_val = '0;
    load_val[WORD_BITS-1:0] = value_i[WORD_BITS-1:0];
    mul_val = '0;
    mul_val[WORD_BITS-1:0] = prod[WORD_BITS-1:0];
    div_val = '0;
    div_val[WORD_BITS-1:0] = {val_q[WORD_BITS-2:0], ge};
  end

  // One byte of long division by ten: the top byte leaves, quotient bits enter.
  always_comb begin
    logic [REM10_BITS-1:0] r;
    logic [REM10_BITS:0]   t;
    logic [DIG_BITS-1:0]   qb;
    logic [DIG_BITS-1:0]   top;
    r   = ctl_i.first ? '0 : rem10_q;
    qb  = '0;
    top = val_q[PAD-1 -: DIG_BITS];
    for (int k = DIG_BITS - 1; k >= 0; k--) begin
      t = {r, top[k]};
      if (t >= TEN) begin
        t     = t - TEN;
        qb[k] = 1'b1;
      end
      r = t[REM10_BITS-1:0];
    end
    d10_rem = r;
    d10_val = {val_q[PAD-DIG_BITS-1:0], qb};
  end

  always_comb begin
    val_d   = val_q;
    div_d   = div_q;
    rem_d   = rem_q;
    rem10_d = rem10_q;
    case (ctl_i.op)
      OP_LOAD: begin
        val_d = load_val;
        div_d = divisor_i[WORD_BITS-1:0];
        rem_d = '0;
      end
      OP_MUL10: begin
        val_d = mul_val;
      end
      OP_DIV10: begin
        val_d   = d10_val;
        rem10_d = d10_rem;
      end
      OP_DIV: begin
        val_d = div_val;
        rem_d = ge ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    div_q   <= div_d;
    rem_q   <= rem_d;
    rem10_q <= rem10_d;
  end

  assign stat_o.ovf      = |prod[WORD_BITS+3:WORD_BITS];
  assign stat_o.val_zero = ~|val_q;
  assign stat_o.div_zero = ~|div_q;

  always_comb begin
    answer_o = '0;
    if (!ctl_i.err) begin
      answer_o[WORD_BITS-1:0] = val_q[WORD_BITS-1:0];
    end
  end

endmodule

FILE: design/u128dr_ctrl.sv
module u128dr_ctrl #(
  parameter int WORD_BITS = u128dr_pkg::DEFAULT_WORD_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic                               cmd_i,
  input  logic signed [u128dr_pkg::SCALE_BITS-1:0] scale_i,
  input  u128dr_pkg::stat_t                  stat_i,
  output u128dr_pkg::ctl_t                   ctl_o,
  output logic                               busy_o,
  output logic                               done_o,
  output logic [u128dr_pkg::STATUS_BITS-1:0] status_o
);
  import u128dr_pkg::*;

  localparam int NCHUNK  = (WORD_BITS + DIG_BITS - 1) / DIG_BITS;
  localparam int CHUNK_W = $clog2(NCHUNK);
  localparam int BIT_W   = $clog2(WORD_BITS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIV10 = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]             state_q, state_d;
  logic                   cmd_q, cmd_d;
  logic                   neg_q, neg_d;
  logic [SCALE_BITS-1:0]  cnt_q, cnt_d;
  logic [CHUNK_W-1:0]     chunk_q, chunk_d;
  logic [BIT_W-1:0]       bit_q, bit_d;
  logic [STATUS_BITS-1:0] status_q, status_d;
  logic                   accept;

  assign busy_o = (state_q != S_IDLE) && (state_q != S_DONE);
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    neg_d     = neg_q;
    cnt_d     = cnt_q;
    chunk_d   = chunk_q;
    bit_d     = bit_q;
    status_d  = status_q;
    ctl_o.op    = OP_HOLD;
    ctl_o.first = (chunk_q == '0);
    ctl_o.err   = (status_q != STATUS_OK);

    case (state_q)
      S_IDLE, S_DONE: begin
        if (accept) begin
          ctl_o.op = OP_LOAD;
          cmd_d    = cmd_i;
          neg_d    = scale_i[SCALE_BITS-1];
          cnt_d    = scale_i[SCALE_BITS-1] ? SCALE_BITS'(-scale_i) : SCALE_BITS'(scale_i);
          status_d = STATUS_OK;
          chunk_d  = '0;
          bit_d    = '0;
          state_d  = S_CHECK;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_CHECK: begin
        if (cmd_q == CMD_DIVIDE) begin
          if (stat_i.div_zero) begin
            status_d = STATUS_DIVZ;
            state_d  = S_DONE;
          end else if (neg_q) begin
            state_d = S_DIV;
          end else begin
            state_d = S_MUL;
          end
        end else if (neg_q) begin
          state_d = S_DIV10;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        if (cnt_q == '0) begin
          state_d = (cmd_q == CMD_DIVIDE) ? S_DIV : S_DONE;
        end else if (stat_i.ovf) begin
          status_d = STATUS_OVF;
          state_d  = S_DONE;
        end else begin
          ctl_o.op = OP_MUL10;
          cnt_d    = cnt_q - 1'b1;
        end
      end
      S_DIV10: begin
        // Once the value reaches zero further digits change nothing.
        if ((chunk_q == '0) && ((cnt_q == '0) || stat_i.val_zero)) begin
          state_d = S_DONE;
        end else begin
          ctl_o.op = OP_DIV10;
          if (chunk_q == CHUNK_W'(NCHUNK - 1)) begin
            chunk_d = '0;
            cnt_d   = cnt_q - 1'b1;
          end else begin
            chunk_d = chunk_q + 1'b1;
          end
        end
      end
      S_DIV: begin
        ctl_o.op = OP_DIV;
        bit_d    = bit_q + 1'b1;
        if (bit_q == BIT_W'(WORD_BITS - 1)) begin
          state_d = S_DONE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cmd_q    <= CMD_RESCALE;
      neg_q    <= 1'b0;
      cnt_q    <= '0;
      chunk_q  <= '0;
      bit_q    <= '0;
      status_q <= STATUS_OK;
    end else begin
      state_q  <= state_d;
      cmd_q    <= cmd_d;
      neg_q    <= neg_d;
      cnt_q    <= cnt_d;
      chunk_q  <= chunk_d;
      bit_q    <= bit_d;
      status_q <= status_d;
    end
  end

  assign done_o   = (state_q == S_DONE);
  assign status_o = status_q;

endmodule

FILE: tb/sv/testbench.sv
module testbench;
  import u128dr_pkg::*;

  localparam int WORD_BITS = DEFAULT_WORD_BITS;
  localparam logic [FULL_BITS-1:0] ALL_ONES = '1;
  localparam logic [FULL_BITS-1:0] WORD_MASK =
    (WORD_BITS >= FULL_BITS) ? ALL_ONES : ((FULL_BITS'(1) << WORD_BITS) - FULL_BITS'(1));
  localparam int RANDOM_PER_PHASE = 300;
  localparam int DRAIN_CYCLES     = 700;
  localparam int CYCLE_LIMIT      = 3000000;
  localparam int N_DIRECTED       = 22;

  typedef struct {
    logic                         cmd;
    logic [FULL_BITS-1:0]         value;
    logic [FULL_BITS-1:0]         divisor;
    logic signed [SCALE_BITS-1:0] scale;
    logic                         typed;   // the answer below is taken as it stands
    logic [FULL_BITS-1:0]         answer;
    logic [STATUS_BITS-1:0]       status;
  } command_row_t;

  typedef struct {
    logic [FULL_BITS-1:0]   answer;
    logic [STATUS_BITS-1:0] status;
  } scaled_answer_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start_i;
  logic                         busy_o;
  logic                         cmd_i;
  logic [FIELD_BITS-1:0]        value_low_i;
  logic [FIELD_BITS-1:0]        value_high_i;
  logic [FIELD_BITS-1:0]        divisor_low_i;
  logic [FIELD_BITS-1:0]        divisor_high_i;
  logic signed [SCALE_BITS-1:0] decimal_scale_i;
  logic                         done_o;
  logic [FIELD_BITS-1:0]        answer_low_o;
  logic [FIELD_BITS-1:0]        answer_high_o;
  logic [STATUS_BITS-1:0]       status_o;

  scaled_answer_t pending_answers[$];
  int             mismatch_count;
  int             cycle_count;
  command_row_t   directed_rows[N_DIRECTED];
  int             sender_idle_pct[3] = '{0, 63, 32};

  u128_decimal_rescale_divide_unit #(
    .WORD_BITS(WORD_BITS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cmd_i          (cmd_i),
    .value_low_i    (value_low_i),
    .value_high_i   (value_high_i),
    .divisor_low_i  (divisor_low_i),
    .divisor_high_i (divisor_high_i),
    .decimal_scale_i(decimal_scale_i),
    .done_o         (done_o),
    .answer_low_o   (answer_low_o),
    .answer_high_o  (answer_high_o),
    .status_o       (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Exact scaling: every multiply by ten is checked against the word, and the
  // first product that leaves it ends the scaling with an overflow.
  function automatic scaled_answer_t scale_divide_predict(input command_row_t row);
    scaled_answer_t       res;
    logic [FULL_BITS-1:0] acc;
    logic [FULL_BITS-1:0] dvs;
    logic [FULL_BITS+3:0] product;
    int                   k;
    logic                 over;
    acc  = row.value & WORD_MASK;
    dvs  = row.divisor & WORD_MASK;
    k    = int'(row.scale);
    over = 1'b0;
    res.status = STATUS_OK;
    if (row.cmd == CMD_DIVIDE && dvs == '0) begin
      res.status = STATUS_DIVZ;
    end else begin
      for (int i = 0; i < k && !over; i++) begin
        product = {4'b0, acc} * (FULL_BITS + 4)'(10);
        if (product > {4'b0, WORD_MASK}) over = 1'b1;
        acc = product[FULL_BITS-1:0];
      end
      if (over) begin
        res.status = STATUS_OVF;
      end else if (row.cmd == CMD_DIVIDE) begin
        acc = acc / dvs;
      end else begin
        for (int i = 0; i < -k; i++) acc = acc / FULL_BITS'(10);
      end
    end
    res.answer = (res.status == STATUS_OK) ? acc : '0;
    return res;
  endfunction

  function automatic command_row_t random_command();
    command_row_t         row;
    logic [31:0]          pick;
    logic [FULL_BITS-1:0] pow;
    int                   s;
    row.cmd     = ($urandom_range(0, 1) == 1) ? CMD_DIVIDE : CMD_RESCALE;
    row.typed   = 1'b0;
    row.answer  = '0;
    row.status  = STATUS_OK;
    s           = $urandom_range(0, 20) - 10;
    row.scale   = SCALE_BITS'(s);
    row.value   = {$urandom, $urandom, $urandom, $urandom} >> $urandom_range(0, 127);
    row.divisor = {$urandom, $urandom, $urandom, $urandom} >> $urandom_range(0, 127);
    case ($urandom_range(0, 7))
      0: begin
        row.value   = {$urandom, $urandom, $urandom, $urandom};
        row.divisor = {$urandom, $urandom, $urandom, $urandom};
      end
      1: begin
        // Sit on the overflow boundary of a multiply by ten to the power s.
        s   = $urandom_range(1, 38);
        pow = FULL_BITS'(1);
        repeat (s) pow = pow * FULL_BITS'(10);
        row.value = ALL_ONES / pow + FULL_BITS'($urandom_range(0, 2)) - FULL_BITS'(1);
        row.scale = SCALE_BITS'(s);
      end
      2: begin
        pick      = $urandom;
        row.scale = pick[SCALE_BITS-1:0];
      end
      default: ;
    endcase
    if ($urandom_range(0, 9) == 0) row.divisor = '0;
    return row;
  endfunction

  task automatic send_command(input command_row_t row, input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i = 1'b0;
      @(negedge clk_i);
    end
    start_i         = 1'b1;
    cmd_i           = row.cmd;
    value_low_i     = row.value[FIELD_BITS-1:0];
    value_high_i    = row.value[FULL_BITS-1:FIELD_BITS];
    divisor_low_i   = row.divisor[FIELD_BITS-1:0];
    divisor_high_i  = row.divisor[FULL_BITS-1:FIELD_BITS];
    decimal_scale_i = row.scale;
    do @(posedge clk_i); while (busy_o);
    if (row.typed) pending_answers.push_back('{row.answer, row.status});
    else pending_answers.push_back(scale_divide_predict(row));
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : result_check
    scaled_answer_t want;
    if (rst_ni && done_o) begin
      if (pending_answers.size() == 0) begin
        $error("result beat with no command outstanding");
        mismatch_count++;
      end else begin
        want = pending_answers.pop_front();
        if (answer_low_o !== want.answer[FIELD_BITS-1:0]) begin
          $error("answer_low: expected %h, actual %h", want.answer[FIELD_BITS-1:0],
                 answer_low_o);
          mismatch_count++;
        end
        if (answer_high_o !== want.answer[FULL_BITS-1:FIELD_BITS]) begin
          $error("answer_high: expected %h, actual %h",
                 want.answer[FULL_BITS-1:FIELD_BITS], answer_high_o);
          mismatch_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    mismatch_count  = 0;
    cycle_count     = 0;
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    cmd_i           = CMD_RESCALE;
    value_low_i     = '0;
    value_high_i    = '0;
    divisor_low_i   = '0;
    divisor_high_i  = '0;
    decimal_scale_i = '0;

    directed_rows = '{
      '{CMD_RESCALE, 128'd0, 128'd0, 7'sd0, 1'b1, 128'd0, STATUS_OK},
      '{CMD_RESCALE, ALL_ONES, ALL_ONES, 7'sd0, 1'b1, ALL_ONES, STATUS_OK},
      '{CMD_RESCALE, ALL_ONES, 128'd0, 7'sd1, 1'b1, 128'd0, STATUS_OVF},
      '{CMD_RESCALE, 128'd1, 128'd0, 7'sd38, 1'b0, 128'd0, STATUS_OK},
      '{CMD_RESCALE, 128'd1, 128'd0, 7'sd39, 1'b1, 128'd0, STATUS_OVF},
      '{CMD_RESCALE, 128'd1, ALL_ONES, 7'sd63, 1'b1, 128'd0, STATUS_OVF},
      '{CMD_RESCALE, ALL_ONES, 128'd0, 7'sh40, 1'b1, 128'd0, STATUS_OK},
      '{CMD_RESCALE, ALL_ONES, 128'd0, -7'sd1, 1'b0, 128'd0, STATUS_OK},
      '{CMD_RESCALE, 128'h1999_9999_9999_9999_9999_9999_9999_9999, 128'd0, 7'sd1,
        1'b0, 128'd0, STATUS_OK},
      '{CMD_RESCALE, 128'h1999_9999_9999_9999_9999_9999_9999_999A, 128'd0, 7'sd1,
        1'b1, 128'd0, STATUS_OVF},
      '{CMD_RESCALE, 128'h8000_0000_0000_0000_0000_0000_0000_0000, 128'd0, 7'sd1,
        1'b1, 128'd0, STATUS_OVF},
      '{CMD_RESCALE, 128'd0, 128'd0, 7'sd63, 1'b1, 128'd0, STATUS_OK},
      '{CMD_RESCALE, 128'd10, 128'd0, -7'sd1, 1'b1, 128'd1, STATUS_OK},
      '{CMD_DIVIDE, ALL_ONES, 128'd0, 7'sd5, 1'b1, 128'd0, STATUS_DIVZ},
      '{CMD_DIVIDE, 128'd0, 128'd0, 7'sh40, 1'b1, 128'd0, STATUS_DIVZ},
      '{CMD_DIVIDE, ALL_ONES, 128'd1, 7'sd0, 1'b1, ALL_ONES, STATUS_OK},
      '{CMD_DIVIDE, ALL_ONES, ALL_ONES, 7'sd0, 1'b1, 128'd1, STATUS_OK},
      '{CMD_DIVIDE, 128'd12345, 128'd7, -7'sd3, 1'b0, 128'd0, STATUS_OK},
      '{CMD_DIVIDE, 128'd1, 128'd3, 7'sd38, 1'b0, 128'd0, STATUS_OK},
      '{CMD_DIVIDE, ALL_ONES, 128'd1, 7'sd63, 1'b1, 128'd0, STATUS_OVF},
      '{CMD_DIVIDE, 128'd0, ALL_ONES, 7'sd63, 1'b1, 128'd0, STATUS_OK},
      '{CMD_DIVIDE, 128'h1_0000_0000_0000_0000, 128'hFFFF_FFFF_FFFF_FFFF, 7'sd2,
        1'b0, 128'd0, STATUS_OK}
    };

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) send_command(directed_rows[i], 0);

    // The receiver cannot hold results off, so only the sender's gaps vary.
    foreach (sender_idle_pct[p]) begin
      repeat (RANDOM_PER_PHASE) send_command(random_command(), sender_idle_pct[p]);
    end
    start_i = 1'b0;

    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
